// ===== rtl/pst_pkg.sv =====
package pst_pkg;

   localparam int unsigned DEF_MAX_NUMBERS = 65536;
   localparam int unsigned DEF_LIST_DEPTH  = 8192;

   localparam int unsigned KIND_W   = 2;
   localparam int unsigned VALUE_W  = 16;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 14;
   localparam int unsigned CALC_W   = 18;

   localparam logic [KIND_W-1:0] KIND_BUILD  = 0;
   localparam logic [KIND_W-1:0] KIND_TEST   = 1;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2;
   localparam logic [KIND_W-1:0] KIND_BAD    = 3;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE   = 1;
   localparam logic [STATUS_W-1:0] STATUS_UNBUILT = 2;

   localparam logic [VALUE_W-1:0] LIMIT_RESET = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
   localparam int unsigned        FIRST_PRIME = 2;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                is_prime;
      logic [VALUE_W-1:0]  prime_value;
      logic [COUNT_W-1:0]  prime_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_SIEVE_TEST,
      ST_SIEVE_CHK,
      ST_CROSS,
      ST_COLLECT,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic fill_init;
      logic fill_step;
      logic sieve_init;
      logic sieve_read;
      logic cross_init;
      logic cross_step;
      logic sieve_next;
      logic collect_init;
      logic collect_step;
      logic build_done;
      logic query;
   } cmd_type;

   typedef struct packed {
      logic fill_more;
      logic sieve_more;
      logic flag_set;
      logic cross_more;
      logic collect_more;
   } stat_type;

endpackage

// ===== rtl/pst_ctrl.sv =====
module pst_ctrl import pst_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [KIND_W-1:0] req_kind,
   input  stat_type          stat,
   output logic              busy,
   output cmd_type           cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && req_kind == KIND_BUILD) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (!stat.fill_more) begin
               state_in = ST_SIEVE_TEST;
            end
         end
         ST_SIEVE_TEST: begin
            state_in = stat.sieve_more ? ST_SIEVE_CHK : ST_COLLECT;
         end
         ST_SIEVE_CHK: begin
            state_in = stat.flag_set ? ST_CROSS : ST_SIEVE_TEST;
         end
         ST_CROSS: begin
            if (!stat.cross_more) begin
               state_in = ST_SIEVE_TEST;
            end
         end
         ST_COLLECT: begin
            if (!stat.collect_more) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_kind == KIND_BUILD) begin
                  cmd.fill_init = 1'b1;
               end else begin
                  cmd.query = 1'b1;
               end
            end
         end
         ST_FILL: begin
            if (stat.fill_more) begin
               cmd.fill_step = 1'b1;
            end else begin
               cmd.sieve_init = 1'b1;
            end
         end
         ST_SIEVE_TEST: begin
            if (stat.sieve_more) begin
               cmd.sieve_read = 1'b1;
            end else begin
               cmd.collect_init = 1'b1;
            end
         end
         ST_SIEVE_CHK: begin
            if (stat.flag_set) begin
               cmd.cross_init = 1'b1;
            end else begin
               cmd.sieve_next = 1'b1;
            end
         end
         ST_CROSS: begin
            if (stat.cross_more) begin
               cmd.cross_step = 1'b1;
            end else begin
               cmd.sieve_next = 1'b1;
            end
         end
         ST_COLLECT: begin
            cmd.collect_step = stat.collect_more;
         end
         ST_DRAIN: begin
            cmd.build_done = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ===== rtl/pst_datapath.sv =====
module pst_datapath import pst_pkg::*; #(
   parameter int unsigned MAX_NUMBERS = DEF_MAX_NUMBERS,
   parameter int unsigned LIST_DEPTH  = DEF_LIST_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  req_type            req_data,
   input  cmd_type            cmd,
   input  logic               csr_write_en,
   input  logic [VALUE_W-1:0] csr_write_data,
   output stat_type           stat,
   output logic               rsp_strobe,
   output rsp_type            rsp_data
);

   localparam int unsigned NUM_W  = $clog2(MAX_NUMBERS);
   localparam int unsigned LIST_W = $clog2(LIST_DEPTH);
   localparam int unsigned CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int unsigned CMP_W  = (CNT_W > VALUE_W) ? CNT_W : VALUE_W;
   localparam int unsigned SAT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam logic [VALUE_W-1:0] TOP_LIM =
      (MAX_NUMBERS - 1 > 65535) ? '1 : VALUE_W'(MAX_NUMBERS - 1);

   logic               flags [MAX_NUMBERS];
   logic [VALUE_W-1:0] prime_list [LIST_DEPTH];

   logic [VALUE_W-1:0]  limit_ff, limit_in;
   logic                built_ff, built_in;
   logic [CALC_W-1:0]   n_ff, n_in;
   logic [VALUE_W-1:0]  p_ff, p_in;
   logic [CALC_W-1:0]   sq_ff, sq_in;
   logic [CALC_W-1:0]   m_ff, m_in;
   logic [VALUE_W-1:0]  nd_ff, nd_in;
   logic                chk_ff, chk_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                res_valid_ff, res_valid_in;
   logic [KIND_W-1:0]   res_kind_ff, res_kind_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                res_built_ff, res_built_in;
   logic                flag_rd_ff;
   logic [VALUE_W-1:0]  list_rd_ff;

   logic [VALUE_W-1:0]  lim;
   logic [CALC_W-1:0]   lim_x;
   logic                flag_we;
   logic [NUM_W-1:0]    flag_wa;
   logic                flag_wd;
   logic [NUM_W-1:0]    flag_ra;
   logic                list_we;
   logic [LIST_W-1:0]   list_wa;
   logic [LIST_W-1:0]   list_ra;
   logic [STATUS_W-1:0] q_status;
   logic [SAT_W-1:0]    cnt_wide;
   logic [COUNT_W-1:0]  count_sat;
   logic                res_ok;

   assign lim   = (limit_ff > TOP_LIM) ? TOP_LIM : limit_ff;
   assign lim_x = CALC_W'(lim);

   assign stat.fill_more    = n_ff <= lim_x;
   assign stat.sieve_more   = sq_ff <= lim_x;
   assign stat.flag_set     = flag_rd_ff;
   assign stat.cross_more   = m_ff <= lim_x;
   assign stat.collect_more = n_ff <= lim_x;

   assign flag_we = cmd.fill_step | cmd.cross_step;
   assign flag_wa = cmd.fill_step ? NUM_W'(n_ff) : NUM_W'(m_ff);
   assign flag_wd = cmd.fill_step & (n_ff >= CALC_W'(FIRST_PRIME));

   always_comb begin
      if (cmd.sieve_read) begin
         flag_ra = NUM_W'(p_ff);
      end else if (cmd.collect_step) begin
         flag_ra = NUM_W'(n_ff);
      end else begin
         flag_ra = NUM_W'(req_data.value);
      end
   end

   assign list_we = chk_ff & flag_rd_ff & (cnt_ff < CNT_W'(LIST_DEPTH));
   assign list_wa = LIST_W'(cnt_ff);
   assign list_ra = LIST_W'(req_data.value - VALUE_W'(1));

   always_ff @(posedge clock) begin
      if (flag_we) begin
         flags[flag_wa] <= flag_wd;
      end
      flag_rd_ff <= flags[flag_ra];
   end

   always_ff @(posedge clock) begin
      if (list_we) begin
         prime_list[list_wa] <= nd_ff;
      end
      list_rd_ff <= prime_list[list_ra];
   end

   always_comb begin
      q_status = STATUS_OK;
      case (req_data.kind)
         KIND_TEST: begin
            if (!built_ff) begin
               q_status = STATUS_UNBUILT;
            end else if (req_data.value > lim) begin
               q_status = STATUS_RANGE;
            end
         end
         KIND_LOOKUP: begin
            if (!built_ff) begin
               q_status = STATUS_UNBUILT;
            end else if (req_data.value == '0 ||
                         CMP_W'(req_data.value) > CMP_W'(cnt_ff)) begin
               q_status = STATUS_RANGE;
            end
         end
         default: begin
            q_status = STATUS_RANGE;
         end
      endcase
   end

   always_comb begin
      limit_in      = limit_ff;
      built_in      = built_ff;
      n_in          = n_ff;
      p_in          = p_ff;
      sq_in         = sq_ff;
      m_in          = m_ff;
      nd_in         = nd_ff;
      chk_in        = cmd.collect_step;
      cnt_in        = cnt_ff;
      res_valid_in  = 1'b0;
      res_kind_in   = res_kind_ff;
      res_status_in = res_status_ff;
      res_built_in  = res_built_ff;

      if (csr_write_en) begin
         limit_in = csr_write_data;
         built_in = 1'b0;
      end
      if (cmd.fill_init) begin
         n_in = '0;
      end
      if (cmd.fill_step) begin
         n_in = n_ff + CALC_W'(1);
      end
      if (cmd.sieve_init) begin
         p_in  = VALUE_W'(FIRST_PRIME);
         sq_in = CALC_W'(FIRST_PRIME * FIRST_PRIME);
      end
      if (cmd.sieve_next) begin
         p_in  = p_ff + VALUE_W'(1);
         sq_in = sq_ff + CALC_W'({p_ff, 1'b1});
      end
      if (cmd.cross_init) begin
         m_in = sq_ff;
      end
      if (cmd.cross_step) begin
         m_in = m_ff + CALC_W'(p_ff);
      end
      if (cmd.collect_init) begin
         n_in   = CALC_W'(FIRST_PRIME);
         cnt_in = '0;
      end
      if (cmd.collect_step) begin
         n_in  = n_ff + CALC_W'(1);
         nd_in = VALUE_W'(n_ff);
      end
      if (list_we) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.build_done) begin
         built_in      = 1'b1;
         res_valid_in  = 1'b1;
         res_kind_in   = KIND_BUILD;
         res_status_in = STATUS_OK;
         res_built_in  = 1'b1;
      end
      if (cmd.query) begin
         res_valid_in  = 1'b1;
         res_kind_in   = req_data.kind;
         res_status_in = q_status;
         res_built_in  = built_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         built_ff     <= 1'b0;
         chk_ff       <= 1'b0;
         cnt_ff       <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         built_ff     <= built_in;
         chk_ff       <= chk_in;
         cnt_ff       <= cnt_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      p_ff          <= p_in;
      sq_ff         <= sq_in;
      m_ff          <= m_in;
      nd_ff         <= nd_in;
      res_kind_ff   <= res_kind_in;
      res_status_ff <= res_status_in;
      res_built_ff  <= res_built_in;
   end

   assign res_ok    = res_status_ff == STATUS_OK;
   assign cnt_wide  = SAT_W'(cnt_ff);
   assign count_sat = (cnt_wide > SAT_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(cnt_wide);

   assign rsp_strobe           = res_valid_ff;
   assign rsp_data.status      = res_status_ff;
   assign rsp_data.is_prime    = (res_kind_ff == KIND_TEST && res_ok) ? flag_rd_ff : 1'b0;
   assign rsp_data.prime_value = (res_kind_ff == KIND_LOOKUP && res_ok) ? list_rd_ff : '0;
   assign rsp_data.prime_count = (res_built_ff && res_kind_ff != KIND_BAD) ? count_sat : '0;

endmodule

// ===== rtl/prime_sieve_table_unit.sv =====
// Sieve of Eratosthenes table with prime test and k-th prime lookup.
// Request channel: drive req_data with start; the request is taken at a
// clock edge where start is high and busy is low.
// Result channel: rsp_data is valid for the single cycle in which rsp_strobe
// is high; the receiver cannot stall it and must take it in that cycle.
// csr_write_en/csr_write_data set the sieve limit; a write drops the built
// table until the next build request.
// Test and lookup requests: one flag or list memory read, result one cycle
// after acceptance, and a new query may be taken every cycle.
// Build request: busy for limit + 2 fill cycles, two check cycles per
// candidate p with p*p <= limit plus one, one cycle per cross-out plus one
// per prime p that crosses, limit collect cycles (one for a limit below two)
// and one drain cycle; the flag walk, one entry per cycle, sets this.
// The result strobes in the first cycle with busy low again.
// Reset: limit returns to 65535 and the table counts as not built; the flag
// and list memories are not cleared.
module prime_sieve_table_unit import pst_pkg::*; #(
   parameter int unsigned MAX_NUMBERS = DEF_MAX_NUMBERS,
   parameter int unsigned LIST_DEPTH  = DEF_LIST_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   input  logic               csr_write_en,
   input  logic [VALUE_W-1:0] csr_write_data,
   output logic               rsp_strobe,
   output rsp_type            rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   pst_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_data.kind),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   pst_datapath #(
      .MAX_NUMBERS (MAX_NUMBERS),
      .LIST_DEPTH  (LIST_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_data       (req_data),
      .cmd            (cmd),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .stat           (stat),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data)
   );

   a_build_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.kind == KIND_BUILD) |=> busy)
      else $error("build request did not start the sieve");

   a_query_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.kind != KIND_BUILD) |=> (rsp_strobe && !busy))
      else $error("query request gave no result in the next cycle");

   a_error_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != STATUS_OK) |->
         (!rsp_data.is_prime && rsp_data.prime_value == '0))
      else $error("error result carries data");

   a_build_result: assert property (@(posedge clock) disable iff (reset)
      (cmd.build_done) |=> (rsp_strobe && rsp_data.status == STATUS_OK))
      else $error("build finished without an ok result");

endmodule
